[design/mackey_glass_rk4_generator_core_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the Mackey-Glass RK4 generator
// Shared concurrent assertion forms, clocked on clk; MGRK_ASSERT is quiet during rst.
// ---------------------------------------------------------------------------
`ifndef MACKEY_GLASS_RK4_GENERATOR_CORE_ASSERT_SVH
`define MACKEY_GLASS_RK4_GENERATOR_CORE_ASSERT_SVH

// Checked property under reset gating
`define MGRK_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property that also holds through reset
`define MGRK_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/mgrk_pkg.sv]
// ---------------------------------------------------------------------------
// mgrk_pkg
// Types, constants and helpers shared by the generator controller,
// datapath and top level.
// ---------------------------------------------------------------------------
package mgrk_pkg;

  localparam int HISTORY_DEPTH = 256;
  localparam int RING_AW       = 8;
  localparam int LEN_W         = 9;
  localparam int FRAC_BITS     = 28;
  localparam int NUM_UOPS      = 19;
  localparam int UIDX_W        = 5;

  localparam logic [LEN_W-1:0] DEPTH_LEN = 9'd256;
  localparam logic [63:0] ONE_Q    = 64'd1 << FRAC_BITS;
  localparam logic [63:0] POW_CAP  = 64'd1 << 62;
  localparam logic [63:0] VMAX     = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] VMIN_MAG = 64'h0000_0000_8000_0000;
  localparam logic [31:0] HALF_Q   = 32'd1 << (FRAC_BITS - 1);
  localparam logic signed [35:0] SAT_HI = 36'sd2147483647;
  localparam logic signed [35:0] SAT_LO = -36'sd2147483648;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_COEF_A    = 3'd0,
    REG_COEF_B    = 3'd1,
    REG_STEP_SIZE = 3'd2,
    REG_INITIAL   = 3'd3,
    REG_DELAY     = 3'd4
  } reg_idx_t;

  localparam logic [30:0] COEF_A_RST    = 31'd53687091;
  localparam logic [30:0] COEF_B_RST    = 31'd26843546;
  localparam logic [30:0] STEP_RST      = 31'd26843546;
  localparam logic [31:0] INITIAL_RST   = 32'd322122547;
  localparam logic [8:0]  DELAY_RST     = 9'd170;

  typedef struct packed {
    logic [30:0]        coef_a;
    logic [30:0]        coef_b;
    logic [30:0]        step_size;
    logic signed [31:0] initial_value;
    logic [8:0]         delay_length;
  } cfg_t;

  typedef enum logic [3:0] {
    U_P2, U_P4, U_P8, U_P10, U_HILL, U_AFD,
    U_BX, U_HK1, U_HK2, U_HALF, U_FULL, U_FIN
  } uop_t;

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_READ, S_LOAD, S_RUN, S_WAIT, S_COMMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic prep;
    logic rd;
    logic dload;
    logic go;
    logic commit;
    uop_t op;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic out_free;
  } stat_t;

  // micro-op program for one RK4 step
  function automatic uop_t uop_at(input logic [UIDX_W-1:0] idx);
    uop_t u;
    case (idx)
      5'd0:  u = U_P2;
      5'd1:  u = U_P4;
      5'd2:  u = U_P8;
      5'd3:  u = U_P10;
      5'd4:  u = U_HILL;
      5'd5:  u = U_AFD;
      5'd6:  u = U_BX;
      5'd7:  u = U_HK1;
      5'd8:  u = U_HALF;
      5'd9:  u = U_BX;
      5'd10: u = U_HK2;
      5'd11: u = U_HALF;
      5'd12: u = U_BX;
      5'd13: u = U_HK2;
      5'd14: u = U_FULL;
      5'd15: u = U_BX;
      5'd16: u = U_HK1;
      5'd17: u = U_FIN;
      default: u = U_FIN;
    endcase
    return u;
  endfunction

  function automatic logic uop_is_div(input uop_t u);
    return (u == U_HILL) || (u == U_FIN);
  endfunction

  function automatic logic uop_is_alu(input uop_t u);
    return u == U_FULL;
  endfunction

  function automatic logic signed [35:0] sx36(input logic signed [31:0] v);
    return {{4{v[31]}}, v};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) r = 32'sh7FFF_FFFF;
    else if (v < SAT_LO) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

endpackage

[design/mackey_glass_rk4_generator_core.sv]
// ---------------------------------------------------------------------------
// mackey_glass_rk4_generator_core
// Mackey-Glass series generator, one RK4 step per transfer.
// ---------------------------------------------------------------------------
// Each accepted transfer (restart flag) yields one result: the series value
// before the step and the elapsed time after it, Q4.28 / Q20.28. An item
// passes through setup (accept, restart and ring wrap, ring read, operand
// load), 15 rounded products on one shared 32x32 multiplier (four partial
// products, rounding, handoff), the full-step argument, the Hill term
// d/(1+d^10) on a one-bit-per-cycle divider, the final divide by six by
// constant multiplication, and commit; no new transfer is taken before
// the commit. A result that is not taken holds the commit and with it the
// input. The delay ring is a 256-entry memory with a valid bit per entry,
// so restart clears it at once; no clearing pass follows reset.
// Registers (APB, byte address 4*i): coef_a, coef_b, step_size,
// initial_value, delay_length. Write them only while the block is idle.
module mackey_glass_rk4_generator_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               restart,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] sample,
  output logic [47:0]        elapsed_time
);

  mgrk_pkg::cfg_t  cfg;
  mgrk_pkg::cmd_t  cmd;
  mgrk_pkg::stat_t stat;
  mgrk_pkg::reg_idx_t ridx;

  assign pready = 1'b1;
  assign ridx   = mgrk_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coef_a        <= mgrk_pkg::COEF_A_RST;
      cfg.coef_b        <= mgrk_pkg::COEF_B_RST;
      cfg.step_size     <= mgrk_pkg::STEP_RST;
      cfg.initial_value <= $signed(mgrk_pkg::INITIAL_RST);
      cfg.delay_length  <= mgrk_pkg::DELAY_RST;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        mgrk_pkg::REG_COEF_A:    cfg.coef_a        <= pwdata[30:0];
        mgrk_pkg::REG_COEF_B:    cfg.coef_b        <= pwdata[30:0];
        mgrk_pkg::REG_STEP_SIZE: cfg.step_size     <= pwdata[30:0];
        mgrk_pkg::REG_INITIAL:   cfg.initial_value <= $signed(pwdata);
        mgrk_pkg::REG_DELAY:     cfg.delay_length  <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      mgrk_pkg::REG_COEF_A:    prdata = {1'b0, cfg.coef_a};
      mgrk_pkg::REG_COEF_B:    prdata = {1'b0, cfg.coef_b};
      mgrk_pkg::REG_STEP_SIZE: prdata = {1'b0, cfg.step_size};
      mgrk_pkg::REG_INITIAL:   prdata = cfg.initial_value;
      mgrk_pkg::REG_DELAY:     prdata = {23'd0, cfg.delay_length};
      default:                 prdata = '0;
    endcase
  end

  mgrk_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  mgrk_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .stat         (stat),
    .restart      (restart),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sample       (sample),
    .elapsed_time (elapsed_time)
  );

endmodule

[design/mgrk_ctrl.sv]
// ---------------------------------------------------------------------------
// mgrk_ctrl
// Sequencer: takes a transfer, walks the RK4 micro-op program and hands
// the result to the output register.
// ---------------------------------------------------------------------------
`include "mackey_glass_rk4_generator_core_assert.svh"

module mgrk_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  mgrk_pkg::stat_t stat,
  output mgrk_pkg::cmd_t  cmd
);

  mgrk_pkg::state_t state, state_next;
  logic [mgrk_pkg::UIDX_W-1:0] idx, idx_next;
  logic last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mgrk_pkg::S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  assign last = (idx == mgrk_pkg::UIDX_W'(mgrk_pkg::NUM_UOPS - 2));

  always_comb begin
    state_next = state;
    idx_next   = idx;
    cmd        = '0;
    cmd.op     = mgrk_pkg::uop_at(idx);
    in_stall   = 1'b1;
    unique case (state)
      mgrk_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = mgrk_pkg::S_PREP;
        end
      end
      mgrk_pkg::S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = mgrk_pkg::S_READ;
      end
      mgrk_pkg::S_READ: begin
        cmd.rd     = 1'b1;
        state_next = mgrk_pkg::S_LOAD;
      end
      mgrk_pkg::S_LOAD: begin
        cmd.dload  = 1'b1;
        idx_next   = '0;
        state_next = mgrk_pkg::S_RUN;
      end
      mgrk_pkg::S_RUN: begin
        cmd.go = 1'b1;
        if (mgrk_pkg::uop_is_alu(cmd.op)) begin
          idx_next   = idx + 1'b1;
          state_next = last ? mgrk_pkg::S_COMMIT : mgrk_pkg::S_RUN;
        end else begin
          state_next = mgrk_pkg::S_WAIT;
        end
      end
      mgrk_pkg::S_WAIT: begin
        if (mgrk_pkg::uop_is_div(cmd.op) ? stat.div_done : stat.mul_done) begin
          idx_next   = idx + 1'b1;
          state_next = last ? mgrk_pkg::S_COMMIT : mgrk_pkg::S_RUN;
        end
      end
      mgrk_pkg::S_COMMIT: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = mgrk_pkg::S_IDLE;
        end
      end
      default: state_next = mgrk_pkg::S_IDLE;
    endcase
  end

  `MGRK_ASSERT(a_mul_done_in_wait, stat.mul_done |-> state == mgrk_pkg::S_WAIT, "mul done outside wait")
  `MGRK_ASSERT(a_div_done_in_wait, stat.div_done |-> state == mgrk_pkg::S_WAIT, "div done outside wait")
  `MGRK_ASSERT(a_accept_to_prep, cmd.accept |=> state == mgrk_pkg::S_PREP, "accept did not start step")

endmodule

[design/mgrk_datapath.sv]
// ---------------------------------------------------------------------------
// mgrk_datapath
// State, delay ring, shared 32x32 multiplier, bit-serial divider for the
// Hill term, constant divide by six and output register of the generator.
// ---------------------------------------------------------------------------
module mgrk_datapath (
  input  logic                clk,
  input  logic                rst,
  input  mgrk_pkg::cfg_t      cfg,
  input  mgrk_pkg::cmd_t      cmd,
  output mgrk_pkg::stat_t     stat,
  input  logic                restart,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  sample,
  output logic [47:0]         elapsed_time
);

  // series state
  logic signed [31:0] x, xn, xs, fd, afd, dv, k;
  logic signed [35:0] s;
  logic [47:0] tacc;
  logic [mgrk_pkg::RING_AW-1:0] pos;
  logic restart_q;

  // ring
  logic [31:0] ring [mgrk_pkg::HISTORY_DEPTH];
  logic [mgrk_pkg::HISTORY_DEPTH-1:0] ring_vld;
  logic [31:0] rdata;
  logic rvld;

  // hill function terms
  logic [31:0] u;
  logic dneg;
  logic [62:0] p2, p4, p8, p10;

  logic [mgrk_pkg::LEN_W-1:0] len;
  logic len_nz;
  logic [47:0] tnext;

  assign len    = (cfg.delay_length > mgrk_pkg::DEPTH_LEN) ? mgrk_pkg::DEPTH_LEN
                                                            : cfg.delay_length;
  assign len_nz = (len != '0);
  assign tnext  = tacc + {17'd0, cfg.step_size};

  // ---------------- multiplier operand select ----------------
  logic [63:0] ma, mb, mcap;
  logic mneg;
  logic signed [31:0] sa, sb;

  always_comb begin
    sa = '0;
    sb = '0;
    unique case (cmd.op)
      mgrk_pkg::U_AFD:  begin sa = $signed({1'b0, cfg.coef_a});    sb = fd; end
      mgrk_pkg::U_BX:   begin sa = $signed({1'b0, cfg.coef_b});    sb = xs; end
      mgrk_pkg::U_HK1,
      mgrk_pkg::U_HK2:  begin sa = $signed({1'b0, cfg.step_size}); sb = dv; end
      mgrk_pkg::U_HALF: begin sa = $signed(mgrk_pkg::HALF_Q);      sb = k;  end
      default: ;
    endcase
    mneg = sa[31] ^ sb[31];
    mcap = mneg ? mgrk_pkg::VMIN_MAG : mgrk_pkg::VMAX;
    ma   = {32'd0, mgrk_pkg::mag32(sa)};
    mb   = {32'd0, mgrk_pkg::mag32(sb)};
    unique case (cmd.op)
      mgrk_pkg::U_P2:  begin ma = {32'd0, u};  mb = {32'd0, u};  end
      mgrk_pkg::U_P4:  begin ma = {1'b0, p2}; mb = {1'b0, p2}; end
      mgrk_pkg::U_P8:  begin ma = {1'b0, p4}; mb = {1'b0, p4}; end
      mgrk_pkg::U_P10: begin ma = {1'b0, p8}; mb = {1'b0, p2}; end
      default: ;
    endcase
    if (cmd.op == mgrk_pkg::U_P2 || cmd.op == mgrk_pkg::U_P4 ||
        cmd.op == mgrk_pkg::U_P8 || cmd.op == mgrk_pkg::U_P10) begin
      mneg = 1'b0;
      mcap = mgrk_pkg::POW_CAP;
    end
  end

  // ---------------- multiplier: four partial products ----------------
  logic [63:0] ma_r, mb_r, mcap_r, pp, mres;
  logic mneg_r, mbusy, mdone;
  logic [2:0] ph;
  logic [1:0] psh;
  logic [127:0] macc, mrnd;
  logic [31:0] pa, pb;
  logic [63:0] mr64;
  logic mover;
  logic signed [31:0] sres;
  logic uop_div, uop_alu;

  assign uop_div = mgrk_pkg::uop_is_div(cmd.op);
  assign uop_alu = mgrk_pkg::uop_is_alu(cmd.op);

  assign pa    = ph[1] ? ma_r[63:32] : ma_r[31:0];
  assign pb    = ph[0] ? mb_r[63:32] : mb_r[31:0];
  assign mrnd  = macc + 128'(mgrk_pkg::ONE_Q >> 1);
  assign mover = |mrnd[127:92];
  assign mr64  = mrnd[91:28];
  assign sres  = mneg_r ? -$signed(mres[31:0]) : $signed(mres[31:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      mbusy <= 1'b0;
      mdone <= 1'b0;
    end else begin
      mdone <= 1'b0;
      if (cmd.go && !uop_div && !uop_alu) begin
        mbusy <= 1'b1;
      end else if (mbusy && ph == 3'd5) begin
        mbusy <= 1'b0;
        mdone <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.go && !uop_div && !uop_alu) begin
      ma_r   <= ma;
      mb_r   <= mb;
      mneg_r <= mneg;
      mcap_r <= mcap;
      macc   <= '0;
      ph     <= '0;
    end else if (mbusy) begin
      ph <= ph + 3'd1;
      if (ph <= 3'd3) begin
        pp  <= pa * pb;
        psh <= {1'b0, ph[1]} + {1'b0, ph[0]};
      end
      if (ph >= 3'd1 && ph <= 3'd4) macc <= macc + ({64'd0, pp} << {psh, 5'd0});
      if (ph == 3'd5) mres <= (mover || mr64 > mcap_r) ? mcap_r : mr64;
    end
  end

  // ---------------- divider: one quotient bit a cycle ----------------
  logic [63:0] dn, dd, rem, q, dn_in, dd_in;
  logic [64:0] rsh;
  logic [6:0] dcnt;
  logic dbusy, ddone, hill_go, fin_go;
  logic [35:0] smag;

  // divide by six as (|s| + 3) / 2 / 3, split at bit 18 since 2^18 = 3 * 87381 + 1
  logic [34:0] fm;
  logic [18:0] ft, ft_r;
  logic [16:0] fmh_r;
  logic [39:0] fprod;
  logic [33:0] fhigh, fq;
  logic fbusy;

  assign smag    = s[35] ? 36'(-s) : 36'(s);
  assign hill_go = cmd.go && (cmd.op == mgrk_pkg::U_HILL);
  assign fin_go  = cmd.go && (cmd.op == mgrk_pkg::U_FIN);

  assign dd_in = mgrk_pkg::ONE_Q + {1'b0, p10};
  assign dn_in = {4'd0, u, 28'd0} + (dd_in >> 1);

  assign fm    = 35'((smag + 36'd3) >> 1);
  assign ft    = {2'b0, fm[34:18]} + {1'b0, fm[17:0]};
  assign fhigh = {17'd0, fmh_r} * 34'd87381;
  // t / 3 for t below 2^19
  assign fprod = {21'd0, ft_r} * 40'd699051;
  assign fq    = fhigh + {15'd0, fprod[39:21]};

  assign rsh = {rem, dn[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
      ddone <= 1'b0;
      fbusy <= 1'b0;
    end else begin
      ddone <= (dbusy && dcnt == 7'd1) || fbusy;
      fbusy <= fin_go;
      if (hill_go) begin
        dbusy <= 1'b1;
      end else if (dbusy && dcnt == 7'd1) begin
        dbusy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hill_go) begin
      dn   <= dn_in;
      dd   <= dd_in;
      rem  <= '0;
      q    <= '0;
      dcnt <= 7'd64;
    end else if (dbusy) begin
      dn   <= dn << 1;
      dcnt <= dcnt - 7'd1;
      if (rsh >= {1'b0, dd}) begin
        rem <= 64'(rsh - {1'b0, dd});
        q   <= {q[62:0], 1'b1};
      end else begin
        rem <= rsh[63:0];
        q   <= {q[62:0], 1'b0};
      end
    end else if (fbusy) begin
      q <= {30'd0, fq};
    end
    if (fin_go) begin
      ft_r  <= ft;
      fmh_r <= fm[34:18];
    end
  end

  // ---------------- writeback ----------------
  logic [31:0] qc;
  logic signed [35:0] inc;
  logic signed [31:0] dsel;

  assign qc   = (q > mgrk_pkg::VMAX) ? mgrk_pkg::VMAX[31:0] : q[31:0];
  assign inc  = s[35] ? -$signed({4'd0, q[31:0]}) : $signed({4'd0, q[31:0]});
  assign dsel = (len_nz && rvld) ? $signed(rdata) : 32'sd0;

  always_ff @(posedge clk) begin
    if (cmd.accept) restart_q <= restart;
    if (cmd.rd) begin
      rdata <= ring[pos];
      rvld  <= ring_vld[pos];
    end
    if (cmd.dload) begin
      u    <= mgrk_pkg::mag32(dsel);
      dneg <= dsel[31];
      xs   <= x;
      s    <= '0;
    end
    if (mdone) begin
      unique case (cmd.op)
        mgrk_pkg::U_P2:  p2  <= mres[62:0];
        mgrk_pkg::U_P4:  p4  <= mres[62:0];
        mgrk_pkg::U_P8:  p8  <= mres[62:0];
        mgrk_pkg::U_P10: p10 <= mres[62:0];
        mgrk_pkg::U_AFD: afd <= sres;
        mgrk_pkg::U_BX:  dv  <= mgrk_pkg::sat32(mgrk_pkg::sx36(afd) - mgrk_pkg::sx36(sres));
        mgrk_pkg::U_HK1: begin
          k <= sres;
          s <= s + mgrk_pkg::sx36(sres);
        end
        mgrk_pkg::U_HK2: begin
          k <= sres;
          s <= s + (mgrk_pkg::sx36(sres) <<< 1);
        end
        mgrk_pkg::U_HALF: xs <= mgrk_pkg::sat32(mgrk_pkg::sx36(x) + mgrk_pkg::sx36(sres));
        default: ;
      endcase
    end
    if (cmd.go && uop_alu) xs <= mgrk_pkg::sat32(mgrk_pkg::sx36(x) + mgrk_pkg::sx36(k));
    if (ddone) begin
      if (cmd.op == mgrk_pkg::U_HILL) fd <= dneg ? -$signed(qc) : $signed(qc);
      else xn <= mgrk_pkg::sat32(mgrk_pkg::sx36(x) + inc);
    end
    if (cmd.commit) begin
      sample       <= x;
      elapsed_time <= tnext;
      if (len_nz) ring[pos] <= xn;
    end
  end

  // control-type state: series value, position, time, valid bits, output flag
  always_ff @(posedge clk) begin
    if (rst) begin
      x         <= $signed(mgrk_pkg::INITIAL_RST);
      pos       <= '0;
      tacc      <= '0;
      ring_vld  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cmd.prep) begin
        if (restart_q) begin
          x        <= cfg.initial_value;
          ring_vld <= '0;
          pos      <= '0;
          tacc     <= '0;
        end else if (len_nz && {1'b0, pos} >= len) begin
          pos <= '0;
        end
      end
      if (cmd.commit) begin
        x         <= xn;
        tacc      <= tnext;
        out_valid <= 1'b1;
        if (len_nz) begin
          ring_vld[pos] <= 1'b1;
          pos <= ({1'b0, pos} + 9'd1 >= len) ? '0 : pos + 1'b1;
        end
      end
    end
  end

  assign stat.mul_done = mdone;
  assign stat.div_done = ddone;
  assign stat.out_free = !out_valid || !out_stall;

endmodule
